### src/hcbd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hcbd_pkg: shared types and constants for the chunked body decoder
// Parser phases, status codes, character codes and the hex digit decoder.
// ----------------------------------------------------------------------------
package hcbd_pkg;

  localparam int unsigned LINE_MAX = 31;  // longest size line, 8..255

  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;

  typedef enum logic [2:0] {
    PH_SIZE     = 3'd0,
    PH_DATA     = 3'd1,
    PH_TRAIL    = 3'd2,
    PH_TRAIL_LF = 3'd3,
    PH_DONE     = 3'd4,
    PH_ERROR    = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    ST_RUNNING = 2'd0,
    ST_DONE    = 2'd1,
    ST_ERROR   = 2'd2
  } status_e;

  typedef enum logic {
    KIND_BYTE    = 1'b0,
    KIND_RESTART = 1'b1
  } kind_e;

  // one result word, packed as {status, payload_valid, out_byte}
  typedef struct packed {
    status_e    status;
    logic       payload_valid;
    logic [7:0] out_byte;
  } result_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] value;
  } hex_digit_t;

  function automatic hex_digit_t hex_digit(input logic [7:0] c);
    hex_digit_t r;
    r.valid = 1'b1;
    if (c >= 8'h30 && c <= 8'h39) begin
      r.value = c[3:0];
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      r.value = c[3:0] + 4'd9;
    end else begin
      r.valid = 1'b0;
      r.value = 4'd0;
    end
    return r;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return c == 8'h20 || c == 8'h09 || c == 8'h0B || c == 8'h0C;
  endfunction

endpackage
`default_nettype wire

### src/http_chunked_body_decoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// http_chunked_body_decoder: HTTP chunked transfer body decoder
// Parses size lines, passes chunk payload through, checks chunk trailers.
// ----------------------------------------------------------------------------
// Usage:
//   Slave side takes one word per body byte: tdata = byte, tuser = kind
//   (0 = body byte, 1 = restart). Master side returns exactly one word per
//   accepted input word: tdata = payload byte (0 unless payload), tuser =
//   {status, payload_valid}. Status gives the parser state after the byte:
//   running, terminating zero chunk seen, or format error (sticky).
//   Results are registered (output or skid register). Throughput is one
//   byte per clock while s_axis_tready_o is high; the per-byte parser update
//   is a single registered pass over phase, size accumulator and byte counter.
//   A two-word output stage (output register plus skid register) keeps the
//   input open while one result waits; with both full, s_axis_tready_o
//   drops until the receiver takes a word. Nothing is lost on a stall.
//   Reset (rst_ni low) puts the parser at the start of a size line and
//   empties the output stage; a restart word does the same to the parser
//   and yields a result with status running.
// ----------------------------------------------------------------------------
module http_chunked_body_decoder (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] in_byte
  input  wire logic        s_axis_tuser_i,   // [0] kind
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [7:0]       m_axis_tdata_o,   // [7:0] out_byte
  output logic [2:0]       m_axis_tuser_o    // [0] payload_valid, [2:1] status
);
  import hcbd_pkg::*;

  localparam logic [7:0] LineMax = 8'(LINE_MAX);

  phase_e      phase_q, phase_d;
  logic [31:0] remain_q, remain_d;   // payload bytes still due in this chunk
  logic [7:0]  line_chars_q, line_chars_d;
  logic [31:0] hex_accum_q, hex_accum_d;
  logic        hex_stopped_q, hex_stopped_d;
  logic        digits_seen_q, digits_seen_d;

  result_t     res;
  result_t     out_q, skid_q;
  logic        out_v_q, skid_v_q;
  logic        in_fire;
  hex_digit_t  hd;
  logic [7:0]  c;

  assign c       = s_axis_tdata_i;
  assign hd      = hex_digit(c);
  assign in_fire = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    phase_d       = phase_q;
    remain_d      = remain_q;
    line_chars_d  = line_chars_q;
    hex_accum_d   = hex_accum_q;
    hex_stopped_d = hex_stopped_q;
    digits_seen_d = digits_seen_q;
    res.out_byte      = 8'd0;
    res.payload_valid = 1'b0;

    if (kind_e'(s_axis_tuser_i) == KIND_RESTART) begin
      phase_d       = PH_SIZE;
      remain_d      = 32'd0;
      line_chars_d  = 8'd0;
      hex_accum_d   = 32'd0;
      hex_stopped_d = 1'b0;
      digits_seen_d = 1'b0;
    end else begin
      unique case (phase_q)
        PH_SIZE: begin
          priority if (c == CHAR_CR) begin
            // CR on the size line is dropped
          end else if (c == CHAR_LF) begin
            remain_d      = hex_accum_q;
            line_chars_d  = 8'd0;
            hex_accum_d   = 32'd0;
            hex_stopped_d = 1'b0;
            digits_seen_d = 1'b0;
            phase_d       = (hex_accum_q == 32'd0) ? PH_DONE : PH_DATA;
          end else if (line_chars_q >= LineMax) begin
            phase_d = PH_ERROR;
          end else begin
            line_chars_d = line_chars_q + 8'd1;
            if (!hex_stopped_q) begin
              if (hd.valid) begin
                // saturate once a shift would drop set bits
                hex_accum_d   = (hex_accum_q[31:28] != 4'd0) ? 32'hFFFF_FFFF
                                : {hex_accum_q[27:0], hd.value};
                digits_seen_d = 1'b1;
              end else if (!(is_blank(c) && !digits_seen_q)) begin
                hex_stopped_d = 1'b1;
              end
            end
          end
        end
        PH_DATA: begin
          res.out_byte      = c;
          res.payload_valid = 1'b1;
          remain_d          = remain_q - 32'd1;
          if (remain_q == 32'd1) phase_d = PH_TRAIL;
        end
        PH_TRAIL: begin
          priority if (c == CHAR_CR) phase_d = PH_TRAIL_LF;
          else if (c == CHAR_LF)     phase_d = PH_SIZE;
          else                       phase_d = PH_ERROR;
        end
        PH_TRAIL_LF: phase_d = (c == CHAR_LF) ? PH_SIZE : PH_ERROR;
        PH_DONE:     phase_d = PH_DONE;
        PH_ERROR:    phase_d = PH_ERROR;
        default:     phase_d = PH_ERROR;
      endcase
    end

    unique case (phase_d)
      PH_DONE:  res.status = ST_DONE;
      PH_ERROR: res.status = ST_ERROR;
      default:  res.status = ST_RUNNING;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_SIZE;
      remain_q      <= 32'd0;
      line_chars_q  <= 8'd0;
      hex_accum_q   <= 32'd0;
      hex_stopped_q <= 1'b0;
      digits_seen_q <= 1'b0;
    end else if (in_fire) begin
      phase_q       <= phase_d;
      remain_q      <= remain_d;
      line_chars_q  <= line_chars_d;
      hex_accum_q   <= hex_accum_d;
      hex_stopped_q <= hex_stopped_d;
      digits_seen_q <= digits_seen_d;
    end
  end

  // output register plus skid word
  assign s_axis_tready_o = !skid_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (m_axis_tready_i) skid_v_q <= 1'b0;
    end else if (in_fire) begin
      if (out_v_q && !m_axis_tready_i) skid_v_q <= 1'b1;
      out_v_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (m_axis_tready_i) out_q <= skid_q;
    end else if (in_fire) begin
      if (out_v_q && !m_axis_tready_i) skid_q <= res;
      else                             out_q  <= res;
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = out_q.out_byte;
  assign m_axis_tuser_o  = {out_q.status, out_q.payload_valid};

  // ---------------------------------------------------------------------------
  // Assertions
  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid word held while output register empty");

  a_data_remain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_DATA |-> remain_q != 32'd0)
    else $error("data phase with no bytes remaining");

  a_payload_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[0] |-> m_axis_tuser_o[2:1] == ST_RUNNING)
    else $error("payload byte reported with terminal status");

  a_no_payload_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o[0] |-> m_axis_tdata_o == 8'd0)
    else $error("non-payload word carries data");

  a_line_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    line_chars_q <= LineMax)
    else $error("size line count beyond limit");

endmodule
`default_nettype wire

### tb/testbench.sv
`default_nettype none
// ----------------------------------------------------------------------------
// testbench: self-checking bench for http_chunked_body_decoder
// Streams directed and random chunked bodies, predicts one result per byte
// and checks every output word under several idle/stall mixes.
// ----------------------------------------------------------------------------
module testbench;
  import hcbd_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned PHASE_WORDS = 370;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
  } body_word_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       s_axis_tvalid_i = 1'b0;
  logic       s_axis_tready_o;
  logic [7:0] s_axis_tdata_i = 8'h00;   // [7:0] in_byte
  logic       s_axis_tuser_i = 1'b0;    // [0] kind
  logic       m_axis_tvalid_o;
  logic       m_axis_tready_i = 1'b0;
  logic [7:0] m_axis_tdata_o;           // [7:0] out_byte
  logic [2:0] m_axis_tuser_o;           // [0] payload_valid, [2:1] status

  http_chunked_body_decoder uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  body_word_t  tx_bytes[$];
  result_t     decoded_q[$];
  int unsigned tx_idle_pct = 0;
  int unsigned rx_stall_pct = 0;
  int unsigned n_queued = 0;
  int unsigned n_words = 0;
  int unsigned n_restarts = 0;
  int unsigned n_results = 0;
  int unsigned n_payload = 0;
  int unsigned n_done = 0;
  int unsigned n_error = 0;
  int unsigned n_errors = 0;
  int unsigned cycles = 0;

  // predicted parser state
  phase_e      dec_phase = PH_SIZE;
  logic [31:0] chunk_len = '0;
  logic [31:0] chunk_cnt = '0;
  logic [31:0] size_acc = '0;
  logic [7:0]  line_cnt = '0;
  logic        size_stopped = 1'b0;
  logic        size_has_digit = 1'b0;

  function automatic void clear_size_line();
    line_cnt = '0;
    size_acc = '0;
    size_stopped = 1'b0;
    size_has_digit = 1'b0;
  endfunction

  function automatic result_t decode_byte(input kind_e kind, input logic [7:0] c);
    result_t r;
    int      d;
    r.out_byte = 8'h00;
    r.payload_valid = 1'b0;
    if (kind == KIND_RESTART) begin
      dec_phase = PH_SIZE;
      chunk_len = '0;
      chunk_cnt = '0;
      clear_size_line();
    end else begin
      case (dec_phase)
        PH_SIZE: begin
          if (c == CHAR_LF) begin
            chunk_len = size_acc;
            clear_size_line();
            if (chunk_len == 0) begin
              dec_phase = PH_DONE;
            end else begin
              chunk_cnt = '0;
              dec_phase = PH_DATA;
            end
          end else if (c != CHAR_CR) begin
            if (line_cnt >= LINE_MAX) begin
              dec_phase = PH_ERROR;
            end else begin
              line_cnt = line_cnt + 8'd1;
              if (!size_stopped) begin
                if (c >= "0" && c <= "9") d = int'(c - "0");
                else if (c >= "A" && c <= "F") d = int'(c - "A") + 10;
                else if (c >= "a" && c <= "f") d = int'(c - "a") + 10;
                else d = -1;
                if (d >= 0) begin
                  // saturate instead of wrapping
                  if (size_acc > 32'h0FFF_FFFF) size_acc = '1;
                  else size_acc = {size_acc[27:0], d[3:0]};
                  size_has_digit = 1'b1;
                end else if (!(size_has_digit == 1'b0 && (c == 8'h20 || c == 8'h09 ||
                                                         c == 8'h0B || c == 8'h0C))) begin
                  size_stopped = 1'b1;
                end
              end
            end
          end
        end
        PH_DATA: begin
          r.out_byte = c;
          r.payload_valid = 1'b1;
          chunk_cnt = chunk_cnt + 32'd1;
          if (chunk_cnt >= chunk_len) dec_phase = PH_TRAIL;
        end
        PH_TRAIL: begin
          if (c == CHAR_CR) dec_phase = PH_TRAIL_LF;
          else if (c == CHAR_LF) dec_phase = PH_SIZE;
          else dec_phase = PH_ERROR;
        end
        PH_TRAIL_LF: dec_phase = (c == CHAR_LF) ? PH_SIZE : PH_ERROR;
        PH_DONE, PH_ERROR: ;
        default: dec_phase = PH_ERROR;
      endcase
    end
    if (dec_phase == PH_DONE) r.status = ST_DONE;
    else if (dec_phase == PH_ERROR) r.status = ST_ERROR;
    else r.status = ST_RUNNING;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH cycle %0d word %0d: %s got 0x%0h want 0x%0h",
             cycles, n_results, what, got, want);
    n_errors++;
  endtask

  task automatic add_item(input kind_e kind, input logic [7:0] data);
    body_word_t w;
    w.kind = kind;
    w.data = data;
    tx_bytes.push_back(w);
    n_queued++;
  endtask

  task automatic add_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) add_item(KIND_BYTE, s[i]);
  endtask

  function automatic logic [7:0] hex_char(input int unsigned n);
    logic [3:0] v;
    v = n[3:0];
    if (v < 10) return "0" + {4'd0, v};
    return ($urandom_range(1) ? "A" : "a") + {4'd0, v} - 8'd10;
  endfunction

  function automatic logic [7:0] blank_char();
    case ($urandom_range(3))
      0: return " ";
      1: return "\t";
      2: return 8'h0B;
      default: return 8'h0C;
    endcase
  endfunction

  // one body: mostly well-formed chunks, now and then a malformed line,
  // a bad trailer or an abort; always closed by a restart
  task automatic add_random_body();
    int unsigned size, sel, nchunks, extra;
    bit          finished;
    finished = 1'b0;
    nchunks = 0;
    while (!finished) begin
      nchunks++;
      sel = $urandom_range(99);
      if (nchunks > 6 || sel < 8) size = 0;
      else if (sel < 14) size = $urandom_range(13, 40);
      else size = $urandom_range(1, 12);
      if ($urandom_range(99) < 88) begin
        repeat ($urandom_range(2)) add_item(KIND_BYTE, blank_char());
        repeat ($urandom_range(2)) add_item(KIND_BYTE, "0");
        if (size > 15) add_item(KIND_BYTE, hex_char(size >> 4));
        add_item(KIND_BYTE, hex_char(size));
        if ($urandom_range(3) == 0) begin
          add_item(KIND_BYTE, ";");
          repeat ($urandom_range(6)) add_item(KIND_BYTE, 8'($urandom_range(8'h20, 8'h7E)));
        end
        if ($urandom_range(1)) add_item(KIND_BYTE, CHAR_CR);
        add_item(KIND_BYTE, CHAR_LF);
        finished = (size == 0);
      end else begin
        finished = 1'b1;
        case ($urandom_range(4))
          0: begin
            // size of 8 to 12 hex digits, up to and beyond 32 bits
            repeat ($urandom_range(8, 12)) add_item(KIND_BYTE, hex_char($urandom));
            add_item(KIND_BYTE, CHAR_LF);
            repeat ($urandom_range(1, 4)) add_item(KIND_BYTE, 8'($urandom_range(255)));
          end
          1: begin
            // line exactly at the length limit, or one past it
            extra = $urandom_range(1);
            size = $urandom_range(1, 15);
            add_item(KIND_BYTE, hex_char(size));
            add_item(KIND_BYTE, ";");
            repeat (LINE_MAX - 2 + extra)
              add_item(KIND_BYTE, 8'($urandom_range(8'h20, 8'h7E)));
            add_item(KIND_BYTE, CHAR_LF);
            finished = (extra != 0);
          end
          2: add_text("0x1f\r\n");
          3: begin
            repeat ($urandom_range(2)) add_item(KIND_BYTE, blank_char());
            if ($urandom_range(1)) add_item(KIND_BYTE, CHAR_CR);
            add_item(KIND_BYTE, CHAR_LF);
          end
          default: begin
            add_item(KIND_BYTE, $urandom_range(1) ? "-" : "+");
            add_item(KIND_BYTE, hex_char($urandom));
            add_item(KIND_BYTE, CHAR_LF);
          end
        endcase
      end
      if (!finished) begin
        if ($urandom_range(24) == 0) begin
          // abort mid-chunk
          repeat ($urandom_range(size)) add_item(KIND_BYTE, 8'($urandom_range(255)));
          add_item(KIND_RESTART, 8'($urandom_range(255)));
          finished = 1'b1;
        end else begin
          repeat (size) add_item(KIND_BYTE, 8'($urandom_range(255)));
          sel = $urandom_range(99);
          if (sel < 85) begin
            add_text("\r\n");
          end else if (sel < 95) begin
            add_item(KIND_BYTE, CHAR_LF);
          end else begin
            if ($urandom_range(1)) add_item(KIND_BYTE, CHAR_CR);
            add_item(KIND_BYTE, 8'($urandom_range(8'h0E, 8'hFF)));
            finished = 1'b1;
          end
        end
      end
    end
    repeat ($urandom_range(3)) add_item(KIND_BYTE, 8'($urandom_range(255)));
    add_item(KIND_RESTART, 8'($urandom_range(255)));
  endtask

  // queue a batch under one idle/stall mix, then hold the sender until drained
  task automatic run_phase(input int unsigned tx_pct, input int unsigned rx_pct,
                           input int unsigned n);
    int unsigned start;
    @(negedge clk_i);
    tx_idle_pct = tx_pct;
    rx_stall_pct = rx_pct;
    start = n_queued;
    while (n_queued - start < n) add_random_body();
    while (tx_bytes.size() != 0 || s_axis_tvalid_i) @(negedge clk_i);
    while (decoded_q.size() != 0) @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin : driver
    body_word_t w;
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        decoded_q.push_back(decode_byte(kind_e'(s_axis_tuser_i), s_axis_tdata_i));
        n_words++;
        if (s_axis_tuser_i == KIND_RESTART) n_restarts++;
      end
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (tx_bytes.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          w = tx_bytes.pop_front();
          s_axis_tvalid_i <= 1'b1;
          s_axis_tdata_i <= w.data;
          s_axis_tuser_i <= w.kind;
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin : monitor
    result_t want;
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        n_results++;
        if (decoded_q.size() == 0) begin
          report_mismatch("word with no result pending",
                          32'({m_axis_tuser_o, m_axis_tdata_o}), 32'd0);
        end else begin
          want = decoded_q.pop_front();
          if (m_axis_tdata_o !== want.out_byte)
            report_mismatch("out_byte", 32'(m_axis_tdata_o), 32'(want.out_byte));
          if (m_axis_tuser_o[0] !== want.payload_valid)
            report_mismatch("payload_valid", 32'(m_axis_tuser_o[0]),
                            32'(want.payload_valid));
          if (m_axis_tuser_o[2:1] !== want.status)
            report_mismatch("status", 32'(m_axis_tuser_o[2:1]), 32'(want.status));
          if (want.payload_valid) n_payload++;
          if (want.status == ST_DONE) n_done++;
          if (want.status == ST_ERROR) n_error++;
        end
      end
      m_axis_tready_i <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still pending", cycles, decoded_q.size());
      $display("http_chunked_body_decoder test failed");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // blanks, hex stopped by a non-hex char, extension, CR before LF
    add_text(" \t2g;x\r\n");
    add_item(KIND_BYTE, 8'h00);
    add_item(KIND_BYTE, 8'hFF);
    // CR and LF in separate words, LF-only trailer, zero chunk ends the body
    add_text("\r\n1\nZ\n0\n");
    add_item(KIND_BYTE, 8'hAA);        // ignored once done
    add_item(KIND_RESTART, 8'hFF);
    add_text("1\n");
    add_item(KIND_BYTE, 8'h5A);
    add_text("Z\n");                   // bad trailer, then ignored while in error
    add_item(KIND_RESTART, 8'h00);

    run_phase(0, 0, PHASE_WORDS);
    run_phase(68, 0, PHASE_WORDS);
    run_phase(0, 68, PHASE_WORDS);
    run_phase(18, 18, PHASE_WORDS);

    repeat (8) @(posedge clk_i);
    $display("Sent %0d words (%0d restarts) over four idle/stall mixes; checked %0d results.",
             n_words, n_restarts, n_results);
    $display("Seen: %0d payload bytes, %0d done and %0d error results, %0d mismatches.",
             n_payload, n_done, n_error, n_errors);
    if (n_errors == 0 && decoded_q.size() == 0) begin
      $display("http_chunked_body_decoder test passed");
    end else begin
      $display("http_chunked_body_decoder test failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
